// ===== rtl/sle_pkg.sv =====
// Shared constants and types for the sequential list engine.
`default_nettype none
package sle_pkg;
    localparam int LIST_DEPTH_DEF = 1024;
    localparam int ACT_W = 3;
    localparam int POS_W = 11;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEDUPE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RDEL   = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic eq;
        logic in_range;
    } t_cmp_res;
endpackage
`default_nettype wire

// ===== rtl/sequential_list_engine.sv =====
// Top level: ordered list store with an iterative read/evaluate/write sequencer.
//  channel | dir | handshake          | fields
//  command | in  | i_valid / o_stall  | i_action i_position i_value i_range_high
//  result  | out | o_valid / i_stall  | o_status o_answer o_list_length
// Each entry visit: RAM read (S_RD), then evaluate and write back (S_EV).
// Insert/delete visit only the entries that move; find/count/range delete walk the
// list (find stops at a match); dedupe walks the rest of it once per kept entry.
// Synchronous active-low reset clears length, sequencer and result valid; no RAM clear.
// o_stall is high while a command is in progress; a held result delays only the end.
`default_nettype none
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [ACT_W-1:0]         i_action,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [WORD_W-1:0] i_value,
    input  wire logic signed [WORD_W-1:0] i_range_high,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [STAT_W-1:0]             o_status,
    output logic [POS_W-1:0]              o_answer,
    output logic [POS_W-1:0]              o_list_length
);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EV, S_KRD, S_KEY, S_INSW, S_DONE
    } t_state;

    t_state                    r_state;
    logic [ACT_W-1:0]          r_act;
    logic signed [WORD_W-1:0]  r_val, r_hi, r_key, r_rdata;
    logic [CW-1:0]             r_n, r_j, r_k, r_w, r_p, r_ans;
    logic [STAT_W-1:0]         r_stat;
    logic                      r_ovalid;
    logic [STAT_W-1:0]         r_o_status;
    logic [POS_W-1:0]          r_o_answer, r_o_len;

    logic signed [WORD_W-1:0]  mem [LIST_DEPTH];

    logic                      we, re;
    logic [CW-1:0]             wa_c, ra_c;
    logic signed [WORD_W-1:0]  wd;
    t_cmp_res                  cmp;
    logic                      accept;
    logic [XW-1:0]             pos_x, n_x, pm1_x, ans_x, len_x;
    logic [CW:0]               j_inc, j_inc2, n_dec;
    logic [CW-1:0]             j_dec;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_status = r_o_status;
    assign o_answer = r_o_answer;
    assign o_list_length = r_o_len;

    assign pos_x = XW'(i_position);
    assign n_x = XW'(r_n);
    assign pm1_x = pos_x - XW'(1);
    assign ans_x = XW'(r_ans);
    assign len_x = XW'(r_n);
    assign j_inc = {1'b0, r_j} + (CW+1)'(1);
    assign j_inc2 = {1'b0, r_j} + (CW+1)'(2);
    assign j_dec = r_j - CW'(1);
    assign n_dec = {1'b0, r_n} - (CW+1)'(1);

    sle_cmp u_cmp (
        .i_data (r_rdata),
        .i_opnd ((r_act == ACT_DEDUPE) ? r_key : r_val),
        .i_lo   (r_val),
        .i_hi   (r_hi),
        .o_res  (cmp)
    );

    always_comb begin
        re = (r_state == S_RD) || (r_state == S_KRD);
        ra_c = r_j;
        if (r_state == S_KRD) begin
            ra_c = r_w;
        end else if (r_act == ACT_INSERT) begin
            ra_c = j_dec;
        end else if (r_act == ACT_DELETE) begin
            ra_c = j_inc[CW-1:0];
        end
        we = 1'b0;
        wa_c = r_j;
        wd = r_rdata;
        if (r_state == S_INSW) begin
            we = 1'b1;
            wa_c = r_p;
            wd = r_val;
        end else if (r_state == S_EV) begin
            case (r_act) inside
                ACT_INSERT, ACT_DELETE: we = 1'b1;
                ACT_RDEL: begin
                    we = !cmp.in_range;
                    wa_c = r_k;
                end
                ACT_DEDUPE: begin
                    we = !cmp.eq;
                    wa_c = r_k;
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa_c[AW-1:0]] <= wd;
        end
        if (re) begin
            r_rdata <= mem[ra_c[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act <= i_action;
                        r_val <= i_value;
                        r_hi <= i_range_high;
                        r_p <= pm1_x[CW-1:0];
                        r_ans <= '0;
                        r_stat <= ST_DONE;
                        r_j <= '0;
                        r_k <= '0;
                        r_w <= '0;
                        r_state <= S_DONE;
                        case (i_action) inside
                            ACT_INSERT: begin
                                if (r_n == CW'(LIST_DEPTH)) begin
                                    r_stat <= ST_FULL;
                                end else if (pos_x == '0 || pos_x > n_x + XW'(1)) begin
                                    r_stat <= ST_BAD;
                                end else begin
                                    r_j <= r_n;
                                    r_state <= (n_x > pm1_x) ? S_RD : S_INSW;
                                end
                            end
                            ACT_DELETE: begin
                                if (pos_x == '0 || pos_x > n_x) begin
                                    r_stat <= ST_BAD;
                                end else begin
                                    r_j <= pm1_x[CW-1:0];
                                    if (pos_x < n_x) begin
                                        r_state <= S_RD;
                                    end else begin
                                        r_n <= n_dec[CW-1:0];
                                    end
                                end
                            end
                            ACT_FIND, ACT_COUNT, ACT_RDEL: begin
                                if (r_n != '0) begin
                                    r_state <= S_RD;
                                end
                            end
                            ACT_DEDUPE: begin
                                if (r_n != '0) begin
                                    r_state <= S_KRD;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD: r_state <= S_EV;
                S_KRD: r_state <= S_KEY;
                S_KEY: begin
                    r_key <= r_rdata;
                    r_j <= r_w + CW'(1);
                    r_k <= r_w + CW'(1);
                    if ({1'b0, r_w} + (CW+1)'(1) < {1'b0, r_n}) begin
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_EV: begin
                    case (r_act)
                        ACT_INSERT: begin
                            r_j <= j_dec;
                            r_state <= (j_dec > r_p) ? S_RD : S_INSW;
                        end
                        ACT_DELETE: begin
                            r_j <= j_inc[CW-1:0];
                            if (j_inc2 >= {1'b0, r_n}) begin
                                r_n <= n_dec[CW-1:0];
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        ACT_FIND: begin
                            r_j <= j_inc[CW-1:0];
                            if (cmp.eq) begin
                                r_ans <= j_inc[CW-1:0];
                                r_state <= S_DONE;
                            end else begin
                                r_state <= (j_inc < {1'b0, r_n}) ? S_RD : S_DONE;
                            end
                        end
                        ACT_COUNT: begin
                            r_j <= j_inc[CW-1:0];
                            if (cmp.in_range) begin
                                r_ans <= r_ans + CW'(1);
                            end
                            r_state <= (j_inc < {1'b0, r_n}) ? S_RD : S_DONE;
                        end
                        ACT_RDEL: begin
                            r_j <= j_inc[CW-1:0];
                            if (j_inc < {1'b0, r_n}) begin
                                r_state <= S_RD;
                                if (!cmp.in_range) begin
                                    r_k <= r_k + CW'(1);
                                end
                            end else begin
                                r_n <= cmp.in_range ? r_k : r_k + CW'(1);
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            // dedupe inner pass against r_key
                            r_j <= j_inc[CW-1:0];
                            if (j_inc < {1'b0, r_n}) begin
                                r_state <= S_RD;
                                if (!cmp.eq) begin
                                    r_k <= r_k + CW'(1);
                                end
                            end else begin
                                r_n <= cmp.eq ? r_k : r_k + CW'(1);
                                r_w <= r_w + CW'(1);
                                if ({1'b0, r_w} + (CW+1)'(1)
                                        < {1'b0, (cmp.eq ? r_k : r_k + CW'(1))}) begin
                                    r_state <= S_KRD;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                        end
                    endcase
                end
                S_INSW: begin
                    r_n <= r_n + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_o_status <= r_stat;
                        r_o_answer <= ans_x[POS_W-1:0];
                        r_o_len <= len_x[POS_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(LIST_DEPTH))
        else $error("list length beyond depth");
    a_wr_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> wa_c <= r_n)
        else $error("write outside list");
    a_ans_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_ans <= r_n)
        else $error("answer beyond length");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("command dropped");
endmodule
`default_nettype wire

// ===== rtl/sle_cmp.sv =====
// Shared compare unit: equality against an operand and signed range test.
`default_nettype none
module sle_cmp
    import sle_pkg::*;
(
    input  wire logic signed [WORD_W-1:0] i_data,
    input  wire logic signed [WORD_W-1:0] i_opnd,
    input  wire logic signed [WORD_W-1:0] i_lo,
    input  wire logic signed [WORD_W-1:0] i_hi,
    output t_cmp_res                      o_res
);
    always_comb begin
        o_res.eq       = (i_data == i_opnd);
        o_res.in_range = (i_data >= i_lo) && (i_data <= i_hi);
    end
endmodule
`default_nettype wire

// ===== test/sequential_list_engine_tb.sv =====
// Self-checking testbench for the sequential list engine: scoreboard class plus drive tasks.
`default_nettype none
module sequential_list_engine_tb;
    import sle_pkg::*;

    localparam int DEPTH = LIST_DEPTH_DEF;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  answer;
        logic [POS_W-1:0]  length;
    } t_outcome;

    class list_scoreboard;
        logic [WORD_W-1:0] entries[$];
        t_outcome pending[$];
        int mismatches;
        int checked;
        int full_hits;
        int bad_hits;

        function bit in_bounds(logic [WORD_W-1:0] w, logic [WORD_W-1:0] lo,
                               logic [WORD_W-1:0] hi);
            return $signed(w) >= $signed(lo) && $signed(w) <= $signed(hi);
        endfunction

        function void note_command(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                   logic [WORD_W-1:0] val, logic [WORD_W-1:0] hi);
            t_outcome o;
            logic [WORD_W-1:0] kept[$];
            int n;
            o = '0;
            n = entries.size();
            case (act)
                ACT_INSERT: begin
                    if (n >= DEPTH) begin
                        o.status = ST_FULL;
                        full_hits++;
                    end else if (pos < 1 || pos > n + 1) begin
                        o.status = ST_BAD;
                        bad_hits++;
                    end else begin
                        entries.insert(pos - 1, val);
                    end
                end
                ACT_DELETE: begin
                    if (pos < 1 || pos > n) begin
                        o.status = ST_BAD;
                        bad_hits++;
                    end else begin
                        entries.delete(pos - 1);
                    end
                end
                ACT_FIND: begin
                    for (int j = 0; j < n; j++) begin
                        if (entries[j] == val) begin
                            o.answer = POS_W'(j + 1);
                            break;
                        end
                    end
                end
                ACT_COUNT: begin
                    foreach (entries[j]) if (in_bounds(entries[j], val, hi)) o.answer++;
                end
                ACT_DEDUPE: begin
                    foreach (entries[j]) begin
                        bit seen;
                        seen = 0;
                        foreach (kept[k]) if (kept[k] == entries[j]) seen = 1;
                        if (!seen) kept.push_back(entries[j]);
                    end
                    entries = kept;
                end
                ACT_RDEL: begin
                    foreach (entries[j]) if (!in_bounds(entries[j], val, hi))
                        kept.push_back(entries[j]);
                    entries = kept;
                end
                default: ;
            endcase
            o.length = POS_W'(entries.size());
            pending.push_back(o);
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected st=%0d ans=%0d len=%0d got st=%0d ans=%0d len=%0d",
                             want.status, want.answer, want.length,
                             got.status, got.answer, got.length);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] range_high;
    logic                     out_valid;
    logic                     out_stall;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         answer;
    logic [POS_W-1:0]         list_length;

    list_scoreboard sb;
    bit  calm_phase;
    bit  hold_phase;
    int  model_len;

    sequential_list_engine dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_action(action), .i_position(position),
        .i_value(value), .i_range_high(range_high),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(status), .o_answer(answer), .o_list_length(list_length)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #40000000;
        $display("FAIL");
        $finish;
    end

    // Issue one command; idle gaps come before the word, never while it waits.
    task automatic send_word(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                             logic [WORD_W-1:0] val, logic [WORD_W-1:0] hi);
        while (!calm_phase && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        position   <= pos;
        value      <= val;
        range_high <= hi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_command(act, pos, val, hi);
        model_len = sb.entries.size();
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return $urandom;
            2: return 32'h8000_0000 + $urandom_range(3);
            default: return 32'hFFFF_FFFF - $urandom_range(3);
        endcase
    endfunction

    task automatic send_random();
        int r;
        logic [POS_W-1:0] p;
        logic [WORD_W-1:0] a, b;
        r = $urandom_range(99);
        p = ($urandom_range(9) == 0) ? POS_W'($urandom)
                                     : POS_W'($urandom_range(model_len + 1));
        a = pick_value();
        b = pick_value();
        if (r < 45)      send_word(ACT_INSERT, p, a, b);
        else if (r < 62) send_word(ACT_DELETE, p, a, b);
        else if (r < 74) send_word(ACT_FIND, p, a, b);
        else if (r < 84) send_word(ACT_COUNT, p, a, b);
        else if (r < 88) send_word(ACT_DEDUPE, p, a, b);
        else if (r < 96) send_word(ACT_RDEL, p, a, b);
        else             send_word(ACT_W'(3'd6 + $urandom_range(1)), p, a, b);
    endtask

    // Result side: random stalls, plus one long hold-off.
    initial begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_phase) begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_phase = 0;
            end
            out_stall <= (!calm_phase && $urandom_range(99) < 30);
            @(posedge clk);
            if (out_valid && !out_stall) sb.check_result('{status, answer, list_length});
        end
    end

    initial begin
        int guard;
        sb = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= '0;
        position <= '0;
        value <= '0;
        range_high <= '0;
        calm_phase = 0;
        hold_phase = 0;
        model_len = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_word(ACT_DELETE, 1, 0, 0);
        send_word(ACT_FIND, 1, 5, 5);
        send_word(ACT_INSERT, 0, 1, 0);
        send_word(ACT_INSERT, 2, 1, 0);
        send_word(ACT_INSERT, 1, 32'h7FFF_FFFF, 0);
        send_word(ACT_INSERT, 1, 32'h8000_0000, 0);
        send_word(ACT_INSERT, 3, 32'h8000_0000, 0);
        send_word(ACT_INSERT, 2, 32'hFFFF_FFFF, 0);
        send_word(ACT_INSERT, 11'h7FF, 3, 0);
        send_word(ACT_FIND, 0, 32'h8000_0000, 0);
        send_word(ACT_FIND, 0, 32'h7FFF_FFFF, 0);
        send_word(ACT_COUNT, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(ACT_COUNT, 0, 5, 4);
        send_word(ACT_COUNT, 11'h7FF, 32'hFFFF_FFFF, 0);
        send_word(3'd6, 1, 0, 0);
        send_word(3'd7, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_DEDUPE, 0, 0, 0);
        send_word(ACT_RDEL, 0, 5, 4);
        send_word(ACT_DELETE, 4, 0, 0);
        send_word(ACT_DELETE, 1, 0, 0);
        send_word(ACT_RDEL, 0, 32'h8000_0000, 32'h7FFF_FFFF);

        // inserts back up while results are held back
        hold_phase = 1;
        for (int i = 0; i < 12; i++) send_word(ACT_INSERT, 1, i % 3, 0);

        for (int i = 0; i < 260; i++) begin
            calm_phase = (i >= 100 && i < 160);
            send_random();
        end
        calm_phase = 0;

        // far-out positions, then bulk range actions
        send_word(ACT_INSERT, 1, 0, 0);
        send_word(ACT_INSERT, 11'h401, 0, 0);
        send_word(ACT_DELETE, 11'h400, 0, 0);
        send_word(ACT_INSERT, 11'h400, 32'h8000_0000, 0);
        send_word(ACT_INSERT, 11'h7FF, 7, 0);
        send_word(ACT_DELETE, 11'h401, 0, 0);
        send_word(ACT_COUNT, 0, 2, 9);
        send_word(ACT_RDEL, 0, 2, 15);
        send_word(ACT_DEDUPE, 0, 0, 0);
        for (int i = 0; i < 280; i++) send_random();
        in_valid <= 1'b0;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 4000000) begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        $display("Ran %0d commands covering all actions; %0d full and %0d bad-position rejects.",
                 sb.checked, sb.full_hits, sb.bad_hits);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
